@@ hw/rtl/scfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_pkg
// shared types and constants of the spi command frame receiver
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam logic [7:0] CMD_ADC  = 8'b1100_0011;
  localparam logic [7:0] CMD_WAVE = 8'b0011_1100;
  localparam logic [7:0] TICK_MAX = 8'hFF;

  localparam logic [7:0] READY_WAIT_RST    = 8'd3;
  localparam logic [7:0] FINALIZE_WAIT_RST = 8'd5;

  localparam logic REG_READY_WAIT    = 1'b0;
  localparam logic REG_FINALIZE_WAIT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_BYTE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAIT_READY = 4'd1,
    PH_CMD        = 4'd2,
    PH_ADC        = 4'd3,
    PH_MODE       = 4'd4,
    PH_FHIGH      = 4'd5,
    PH_FLOW       = 4'd6,
    PH_WAIT_NEXT  = 4'd7,
    PH_FINAL      = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ADC  = 2'd1,
    KIND_WAVE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic       slave_has_data;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        select_level;
    logic        start_transfer;
    logic        sample_valid;
    logic [7:0]  sample_value;
    logic        wave_valid;
    logic [7:0]  wave_mode;
    logic [15:0] wave_freq;
    logic [3:0]  phase_code;
  } result_t;

endpackage

@@ hw/rtl/spi_command_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_command_frame_receiver_top
// master-side spi command frame receiver, one event in and one result out
// ----------------------------------------------------------------------------
// Each request is an event (tick, data-ready edge or received byte) and
// yields exactly one result. A request passes an input register, is resolved
// by the protocol next-state logic and lands in a result register, so one
// request is taken every cycle while the result register is not stalled;
// the result is valid once it is in the result register, and only a stalled
// result register holds up the input. Configuration writes take effect at
// the next edge and are meant for when no request is in flight.
module spi_command_frame_receiver_top
  import scfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // slave_has_data, rx_byte[7:0], zero fill
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // select_level, start_transfer, sample_valid,
                                  // sample_value[7:0], wave_valid, wave_mode[7:0],
                                  // wave_freq[15:0], phase_code[3:0]
);

  logic    item_valid;
  item_t   item;
  result_t res;
  logic    space;
  logic    fire;

  assign fire = item_valid && space;

  scfr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  scfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  scfr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hw/rtl/scfr_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_in_reg
// input register: holds one request until the core takes it
// ----------------------------------------------------------------------------
module scfr_in_reg
  import scfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op             <= in_tuser;
      item_r.slave_has_data <= in_tdata[0];
      item_r.rx_byte        <= in_tdata[8:1];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hw/rtl/scfr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_core
// protocol state, configuration registers and next-state logic for one request
// ----------------------------------------------------------------------------
module scfr_core
  import scfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       fire,
  input  item_t      item,
  output result_t    res
);

  logic [7:0] ready_wait_r, finalize_wait_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  kind_t      kind_r, kind_nxt;
  logic [1:0] pcount_r, pcount_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] fhigh_r, fhigh_nxt;
  logic       pend_r, pend_nxt;
  logic       sel_r, sel_nxt;

  logic [7:0] tick_inc;
  logic       level;
  logic       known_op;

  assign level    = item.slave_has_data;
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_wait_r    <= READY_WAIT_RST;
      finalize_wait_r <= FINALIZE_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_READY_WAIT:    ready_wait_r    <= cfg_wdata;
        REG_FINALIZE_WAIT: finalize_wait_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= 8'd0;
      kind_r   <= KIND_NONE;
      pcount_r <= 2'd0;
      mode_r   <= 8'd0;
      fhigh_r  <= 8'd0;
      pend_r   <= 1'b0;
      sel_r    <= 1'b1;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      kind_r   <= kind_nxt;
      pcount_r <= pcount_nxt;
      mode_r   <= mode_nxt;
      fhigh_r  <= fhigh_nxt;
      pend_r   <= pend_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    kind_nxt   = kind_r;
    pcount_nxt = pcount_r;
    mode_nxt   = mode_r;
    fhigh_nxt  = fhigh_r;
    pend_nxt   = pend_r;
    sel_nxt    = sel_r;
    known_op   = 1'b1;
    res        = '0;

    unique case (op_t'(item.op))
      OP_TICK: begin
        tick_nxt = tick_inc;
        case (phase_r)
          PH_WAIT_READY: begin
            if (tick_inc >= ready_wait_r && level) begin
              phase_nxt          = PH_CMD;
              tick_nxt           = 8'd0;
              res.start_transfer = 1'b1;
            end
          end
          PH_WAIT_NEXT: begin
            if (level) begin
              res.start_transfer = 1'b1;
              tick_nxt           = 8'd0;
              case (kind_r)
                KIND_ADC:  phase_nxt = PH_ADC;
                KIND_WAVE: begin
                  case (pcount_r)
                    2'd1:    phase_nxt = PH_FHIGH;
                    2'd2:    phase_nxt = PH_FLOW;
                    default: phase_nxt = PH_MODE;
                  endcase
                end
                default: ;
              endcase
            end
          end
          PH_FINAL: begin
            if (tick_inc >= finalize_wait_r) begin
              phase_nxt = PH_IDLE;
              tick_nxt  = 8'd0;
            end
          end
          default: ;
        endcase
      end
      OP_EDGE: begin
        if (level) begin
          pend_nxt = 1'b1;
        end
      end
      OP_BYTE: begin
        case (phase_r)
          PH_CMD: begin
            if (item.rx_byte == CMD_ADC || item.rx_byte == CMD_WAVE) begin
              kind_nxt = (item.rx_byte == CMD_ADC) ? KIND_ADC : KIND_WAVE;
              if (level) begin
                res.start_transfer = 1'b1;
                phase_nxt = (item.rx_byte == CMD_ADC) ? PH_ADC : PH_MODE;
              end else begin
                phase_nxt = PH_WAIT_NEXT;
                tick_nxt  = 8'd0;
              end
            end
          end
          PH_ADC: begin
            res.sample_valid = 1'b1;
            res.sample_value = item.rx_byte;
            sel_nxt          = 1'b1;
            phase_nxt        = PH_FINAL;
            tick_nxt         = 8'd0;
          end
          PH_MODE, PH_FHIGH: begin
            if (phase_r == PH_MODE) begin
              mode_nxt   = item.rx_byte;
              pcount_nxt = 2'd1;
            end else begin
              fhigh_nxt  = item.rx_byte;
              pcount_nxt = 2'd2;
            end
            if (level) begin
              res.start_transfer = 1'b1;
              phase_nxt = (phase_r == PH_MODE) ? PH_FHIGH : PH_FLOW;
            end else begin
              phase_nxt = PH_WAIT_NEXT;
              tick_nxt  = 8'd0;
            end
          end
          PH_FLOW: begin
            res.wave_valid = 1'b1;
            res.wave_mode  = mode_r;
            res.wave_freq  = {fhigh_r, item.rx_byte};
            pcount_nxt     = 2'd0;
            mode_nxt       = 8'd0;
            fhigh_nxt      = 8'd0;
            kind_nxt       = KIND_NONE;
            sel_nxt        = 1'b1;
            phase_nxt      = PH_FINAL;
            tick_nxt       = 8'd0;
          end
          default: ;
        endcase
      end
      default: known_op = 1'b0;
    endcase

    // a latched request starts a new exchange once the block is idle
    if (known_op && pend_nxt && phase_nxt == PH_IDLE) begin
      pend_nxt  = 1'b0;
      phase_nxt = PH_WAIT_READY;
      tick_nxt  = 8'd0;
      sel_nxt   = 1'b0;
    end

    res.select_level = sel_nxt;
    res.phase_code   = phase_nxt;
  end

`ifndef NO_ASSERTIONS
  a_start_selected: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.start_transfer |-> !res.select_level)
    else $error("transfer started with chip select released");

  a_one_frame_kind: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(res.sample_valid && res.wave_valid))
    else $error("sample and waveform completed together");

  a_frame_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.sample_valid || res.wave_valid) |->
      res.select_level && res.phase_code == PH_FINAL)
    else $error("frame end without release and finalize");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> sel_r)
    else $error("chip select low while idle");
`endif

endmodule

@@ hw/rtl/scfr_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_out_reg
// result register toward the master-side stream
// ----------------------------------------------------------------------------
module scfr_out_reg
  import scfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        space,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space     = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.phase_code, res_r.wave_freq, res_r.wave_mode,
                       res_r.wave_valid, res_r.sample_value, res_r.sample_valid,
                       res_r.start_transfer, res_r.select_level};

endmodule
